// File: sv/insertion_sorter_core_macros.svh
// Assertion macros used by the insertion sorter checker.
`ifndef INSERTION_SORTER_CORE_MACROS_SVH
`define INSERTION_SORTER_CORE_MACROS_SVH

// same-cycle implication
`define ISC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ISC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/isort_pkg.sv
// Types and constants of the insertion sorter.
package isort_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

// File: sv/isort_ram.sv
// Single-port-write, registered-read store for the insertion sorter.
module isort_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [AW-1:0]                        waddr,
  input  logic signed [isort_pkg::DATA_W-1:0]  wdata,
  input  logic                                 re,
  input  logic [AW-1:0]                        raddr,
  output logic signed [isort_pkg::DATA_W-1:0]  rdata
);
  import isort_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/insertion_sorter_core.sv
// Insertion sorter top level: FSM walking a sorted store in one RAM.
//
//   channel | dir | handshake           | word
//   in      | in  | in_valid/in_stall   | value, last_in
//   out     | out | out_valid/out_stall | sorted_value, last_out, overflow
//
// Insert: held words larger than it move up one slot each (at most one RAM
// read and one write per cycle); a dropped non-last word returns to idle.
// Emit: EMIT_RD reads, EMIT_LD loads; one word per cycle unless stalled.
// rst is synchronous; store contents need no clearing.
// Output register lets the next list start while the last word waits.
module insertion_sorter_core #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  isort_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output isort_pkg::out_word_t  out_word
);
  import isort_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CW-1:0] fill, fill_next;
  logic          dropped, dropped_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] k, k_next;
  logic signed [DATA_W-1:0] val;
  logic          last;

  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic signed [DATA_W-1:0] ram_wdata, ram_rdata;

  logic in_acc, full, gt, out_free, load, k_final;
  logic [CW-1:0] pos_m1, pos_m2, fill_m1, k_p1;

  assign in_acc   = in_valid && !in_stall;
  assign full     = (fill == CW'(CAPACITY));
  assign gt       = ram_rdata > val;
  assign pos_m1   = pos - CW'(1);
  assign pos_m2   = pos - CW'(2);
  assign fill_m1  = fill - CW'(1);
  assign k_p1     = k + CW'(1);
  assign k_final  = (k_p1 == fill);
  assign out_free = !out_valid || !out_stall;

  isort_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            state_next = in_word.last_in ? ST_EMIT_RD : ST_IDLE;
          end else if (fill == '0) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        if (gt) begin
          state_next = (pos_m1 == '0) ? ST_PLACE : ST_SHIFT;
        end else begin
          state_next = last ? ST_EMIT_RD : ST_IDLE;
        end
      end
      ST_PLACE:   state_next = last ? ST_EMIT_RD : ST_IDLE;
      ST_EMIT_RD: state_next = ST_EMIT_LD;
      ST_EMIT_LD: begin
        if (out_free && k_final) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ST_IDLE);
    ram_we       = 1'b0;
    ram_waddr    = pos[AW-1:0];
    ram_wdata    = val;
    ram_re       = 1'b0;
    ram_raddr    = fill_m1[AW-1:0];
    load         = 1'b0;
    fill_next    = fill;
    dropped_next = dropped;
    pos_next     = pos;
    k_next       = k;
    case (state)
      ST_IDLE: begin
        k_next = '0;
        if (in_acc) begin
          pos_next = fill;
          if (full) begin
            dropped_next = 1'b1;
          end else if (fill != '0) begin
            ram_re = 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        ram_we = 1'b1;
        if (gt) begin
          ram_wdata = ram_rdata;
          pos_next  = pos_m1;
          ram_re    = (pos_m1 != '0);
          ram_raddr = pos_m2[AW-1:0];
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      ST_PLACE: begin
        ram_we    = 1'b1;
        fill_next = fill + CW'(1);
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k[AW-1:0];
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          load = 1'b1;
          if (k_final) begin
            fill_next    = '0;
            dropped_next = 1'b0;
          end else begin
            k_next    = k_p1;
            ram_re    = 1'b1;
            ram_raddr = k_p1[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      dropped <= dropped_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos <= pos_next;
    k   <= k_next;
    if (in_acc) begin
      val  <= in_word.value;
      last <= in_word.last_in;
    end
    if (load) begin
      out_word.sorted_value <= ram_rdata;
      out_word.last_out     <= k_final;
      out_word.overflow     <= dropped;
    end
  end

endmodule

// File: sv/isort_checker.sv
// Port-level checker for the insertion sorter, bound to the top level.
`include "insertion_sorter_core_macros.svh"

module isort_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input isort_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_stall,
  input isort_pkg::out_word_t out_word
);
  import isort_pkg::*;

  logic in_last_acc, out_mid_acc;

  assign in_last_acc = in_valid && !in_stall && in_word.last_in;
  assign out_mid_acc = out_valid && !out_stall && !out_word.last_out;

  `ISC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out word dropped under stall")
  `ISC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled out word changed")
  `ISC_ASSERT_NEXT(a_busy_after_last, in_last_acc, in_stall, "input taken during list emission")
  `ISC_ASSERT_NEXT(a_no_gap, out_mid_acc, out_valid, "gap inside emitted list")
  `ISC_ASSERT_NEXT(a_ovf_const, out_mid_acc, out_word.overflow == $past(out_word.overflow), "overflow changed within list")

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_word (out_word)
);
